// ===== sv/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(label, cond, msg)

`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/ccpd_pkg.sv =====
package ccpd_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    localparam int BYTE_W      = 8;
    localparam int LEN_CFG_W   = 6;
    localparam int INDEX_W     = 5;
    localparam int POS_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN      = 1'd1;

    localparam logic [LEN_CFG_W-1:0] PAYLOAD_LEN_RST = 6'd1;
    localparam logic [POS_W-1:0]     POS_IDLE        = 8'hFF;
    localparam logic [POS_W-1:0]     POS_ADDR        = 8'd1;
    localparam logic [POS_W-1:0]     POS_ADDR_CHK    = 8'd2;
    localparam logic [POS_W-1:0]     POS_DATA_FIRST  = 8'd3;
    localparam logic [BYTE_W:0]      HEADER_STEP     = 9'd2;

    typedef struct packed {
        logic start;
        logic bank;
    } ccpd_done_t;

endpackage

// ===== sv/ccpd_mem.sv =====
module ccpd_mem
    import ccpd_pkg::*;
#(
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [BYTE_W-1:0] rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ccpd_parser.sv =====
module ccpd_parser
    import ccpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_take,
    input  logic [BYTE_W-1:0]     in_byte,
    output logic                  at_end,
    output logic                  wr_en,
    output logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1):0] wr_addr,
    output logic [BYTE_W-1:0]     wr_data,
    output ccpd_done_t            done,
    output logic [$clog2(MAX_PAYLOAD + 1)-1:0] done_len
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    logic [BYTE_W-1:0]    exp_addr_reg;
    logic [LEN_CFG_W-1:0] len_cfg_reg;
    logic [BYTE_W-1:0]    hist1_reg, hist1_next;
    logic [BYTE_W-1:0]    hist2_reg, hist2_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [BYTE_W-1:0]    addr_reg, addr_next;
    logic [BYTE_W-1:0]    prev_reg, prev_next;
    logic                 bank_reg, bank_next;

    logic [POS_W-1:0]     len_wide;
    logic [LEN_W-1:0]     eff_len;
    logic [POS_W-1:0]     frame_end;
    logic [POS_W-1:0]     p;
    logic [POS_W-1:0]     data_off;
    logic                 header;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_addr_reg <= '0;
            len_cfg_reg  <= PAYLOAD_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXPECTED_ADDRESS: exp_addr_reg <= cfg_data;
                REG_PAYLOAD_LEN:      len_cfg_reg  <= cfg_data[LEN_CFG_W-1:0];
            endcase
        end
    end

    // length saturated to 1..MAX_PAYLOAD
    always_comb
    begin
        len_wide = POS_W'(len_cfg_reg);
        if (len_wide == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_wide > POS_W'(MAX_PAYLOAD))
        begin
            eff_len = LEN_W'(MAX_PAYLOAD);
        end
        else
        begin
            eff_len = LEN_W'(len_wide);
        end
    end

    assign frame_end = POS_W'({eff_len, 1'b0}) + POS_W'(2);
    assign at_end    = (pos_reg == frame_end);
    assign done_len  = eff_len;
    assign data_off  = pos_reg - POS_DATA_FIRST;

    always_comb
    begin
        hist1_next = hist1_reg;
        hist2_next = hist2_reg;
        pos_next   = pos_reg;
        addr_next  = addr_reg;
        prev_next  = prev_reg;
        bank_next  = bank_reg;
        wr_en      = 1'b0;
        wr_addr    = {bank_reg, data_off[IDX_W:1]};
        wr_data    = in_byte;
        done       = '{start: 1'b0, bank: bank_reg};
        p          = pos_reg;
        header     = ({1'b0, hist1_reg} + HEADER_STEP == {1'b0, hist2_reg}) &&
                     ({1'b0, hist2_reg} + HEADER_STEP == {1'b0, in_byte});

        if (in_take)
        begin
            hist1_next = hist2_reg;
            hist2_next = in_byte;

            if (p == POS_ADDR)
            begin
                addr_next = in_byte;
            end
            else if (p == POS_ADDR_CHK)
            begin
                if (addr_reg != exp_addr_reg || addr_reg != ~in_byte)
                begin
                    p = POS_IDLE;
                end
            end

            if (p >= POS_DATA_FIRST && p <= frame_end)
            begin
                if (p[0])
                begin
                    wr_en     = 1'b1;
                    prev_next = in_byte;
                end
                else if (in_byte != ~prev_reg)
                begin
                    p = POS_IDLE;
                end
            end

            if (p == frame_end)
            begin
                pos_next   = POS_IDLE;
                done.start = 1'b1;
                bank_next  = ~bank_reg;
            end
            else
            begin
                if (header)
                begin
                    p = '0;
                end
                if (p != POS_IDLE)
                begin
                    p = p + POS_W'(1);
                end
                pos_next = p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist1_reg <= '0;
            hist2_reg <= '0;
            pos_reg   <= POS_IDLE;
            addr_reg  <= '0;
            prev_reg  <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            hist1_reg <= hist1_next;
            hist2_reg <= hist2_next;
            pos_reg   <= pos_next;
            addr_reg  <= addr_next;
            prev_reg  <= prev_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ===== sv/ccpd_readout.sv =====
`include "assert_macros.svh"

module ccpd_readout
    import ccpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccpd_done_t           done,
    input  logic [$clog2(MAX_PAYLOAD + 1)-1:0] done_len,
    output logic                 busy,
    output logic                 re,
    output logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1):0] raddr,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [INDEX_W-1:0]   out_index,
    output logic                 out_last
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    logic               active_reg, active_next;
    logic               bank_reg, bank_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic               last_reg, last_next;
    logic               adv;
    logic [LEN_W-1:0]   cnt_inc;

    assign adv     = !out_valid_reg || out_ready;
    assign re      = adv && active_reg;
    assign raddr   = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign cnt_inc = cnt_reg + LEN_W'(1);
    assign busy    = active_reg;

    always_comb
    begin
        active_next    = active_reg;
        bank_next      = bank_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;

        // output stage moves together with the memory read register
        if (adv)
        begin
            out_valid_next = active_reg;
            idx_next       = INDEX_W'(cnt_reg);
            last_next      = (cnt_inc == len_reg);
        end

        if (re)
        begin
            cnt_next = cnt_inc;
            if (cnt_inc == len_reg)
            begin
                active_next = 1'b0;
            end
        end

        if (done.start)
        begin
            active_next = 1'b1;
            bank_next   = done.bank;
            len_next    = done_len;
            cnt_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            bank_reg      <= 1'b0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            bank_reg      <= bank_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = idx_reg;
    assign out_last  = last_reg;

    `ASSERT_HOLDS(a_start_when_idle, !(done.start && active_reg), "packet done during readout")
    `ASSERT_HOLDS(a_cnt_below_len, !active_reg || cnt_reg < len_reg, "read count past length")
    `ASSERT_NEXT(a_final_read_ends, re && cnt_inc == len_reg && !done.start, !active_reg, "readout did not stop")

endmodule

// ===== sv/complement_checked_packet_deframer.sv =====
// Packet deframer for a byte stream with complement-checked fields.
// Input channel s_*: one received byte per item. A packet is a header of
// three bytes h, h+2, h+4, the address byte and its complement, then
// payload_len pairs of a data byte and its complement.
// Output channel m_*: the data bytes of a checked packet, one per item,
// with their index and tlast on the final byte of the packet.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 expected address,
// index 1 payload length (saturated to 1..MAX_PAYLOAD).
// The parser takes a byte whenever s_tvalid and s_tready are high. The byte that
// completes a packet hands the filled bank of the two-bank payload memory to the
// readout, which registers the hand-over and then reads the bank out through the
// memory read register, one byte per cycle, set by the single memory read port.
// The other bank fills meanwhile. If the receiver stalls, the readout holds; a
// completing byte that comes before the previous run is read out waits with s_tready low.
// Reset: address 0, length 1, parser idle, no output pending. The payload
// memory is not cleared; it is always written before it is read.
`include "assert_macros.svh"

module complement_checked_packet_deframer
    import ccpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,    // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // [7:0] payload_byte, [12:8] payload_index
    output logic                   m_tlast
);

    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = IDX_W + 1;

    logic               in_take;
    logic               at_end;
    logic               busy;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;
    ccpd_done_t         done;
    logic [LEN_W-1:0]   done_len;
    logic [INDEX_W-1:0] out_index;

    assign s_tready = !(busy && at_end);
    assign in_take  = s_tvalid && s_tready;

    ccpd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_take   (in_take),
        .in_byte   (s_tdata),
        .at_end    (at_end),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .done      (done),
        .done_len  (done_len)
    );

    ccpd_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ccpd_readout #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_readout (
        .clk       (clk),
        .rst_n     (rst_n),
        .done      (done),
        .done_len  (done_len),
        .busy      (busy),
        .re        (mem_re),
        .raddr     (mem_raddr),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_last  (m_tlast)
    );

    assign m_tdata = {(OUT_TDATA_W - INDEX_W - BYTE_W)'(0), out_index, mem_rdata};

    `ASSERT_HOLDS(a_banks_apart, !(mem_we && mem_re) || mem_waddr[IDX_W] != mem_raddr[IDX_W], "fill and readout share a bank")

endmodule

// ===== tb/complement_checked_packet_deframer_tb.sv =====
module complement_checked_packet_deframer_tb;
    import ccpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 100000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int NUM_PHASES     = 3;
    localparam int PRESSURE_PHASE = 2;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [BYTE_W-1:0]  payload_byte;
        logic [INDEX_W-1:0] payload_index;
        logic               last;
    } payload_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_ADDRESS,
        FLAW_ADDR_COMPLEMENT,
        FLAW_DATA_COMPLEMENT,
        FLAW_TRUNCATED
    } flaw_t;

    typedef struct {
        logic [BYTE_W-1:0] rx_byte;
        bit                typed;
        logic [BYTE_W-1:0] typed_byte;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;    // [7:0] rx_byte
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [7:0] payload_byte, [12:8] payload_index
    logic                   m_tlast;

    complement_checked_packet_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // predictor state
    logic [BYTE_W-1:0]    cfg_address;
    logic [LEN_CFG_W-1:0] cfg_length;
    logic [BYTE_W-1:0]    recent_bytes [3];
    logic [POS_W-1:0]     parse_pos;
    logic [BYTE_W-1:0]    addr_seen;
    logic [BYTE_W-1:0]    last_data;
    logic [BYTE_W-1:0]    payload_bank [2][MAX_PAYLOAD_DEF];
    logic                 fill_bank;

    payload_t expected_payload [$];

    int  fail_count;
    int  cycle_count;
    int  tx_count;
    int  rx_hold;
    bit  tx_idle_on;
    bit  rx_idle_on;

    // min header, max header, header restart after a bad data complement
    directed_row_t directed_rows [26] = '{
        '{8'h00, 1'b0, 8'h00}, '{8'h02, 1'b0, 8'h00}, '{8'h04, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00}, '{8'h00, 1'b0, 8'h00},
        '{8'hFF, 1'b1, 8'h00},
        '{8'hFB, 1'b0, 8'h00}, '{8'hFD, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00},
        '{8'h00, 1'b1, 8'hFF},
        '{8'h10, 1'b0, 8'h00}, '{8'h12, 1'b0, 8'h00}, '{8'h14, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00}, '{8'h30, 1'b0, 8'h00},
        '{8'h32, 1'b0, 8'h00}, '{8'h34, 1'b0, 8'h00}, '{8'h00, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 8'h00}, '{8'h5A, 1'b0, 8'h00}, '{8'hA5, 1'b0, 8'h00}
    };

    logic [LEN_CFG_W-1:0] phase_length [NUM_PHASES] = '{
        6'd63, 6'd0, 6'd2
    };

    function automatic int unsigned active_length();
        if (cfg_length == 0)
            return 1;
        if (cfg_length > MAX_PAYLOAD_DEF)
            return MAX_PAYLOAD_DEF;
        return cfg_length;
    endfunction

    task automatic deframe_byte(input logic [BYTE_W-1:0] b, input bit keep);
        int unsigned len;
        int unsigned end_pos;
        int unsigned p;
        payload_t    item;
        len     = active_length();
        end_pos = 2 * len + 2;
        p       = parse_pos;

        recent_bytes[0] = recent_bytes[1];
        recent_bytes[1] = recent_bytes[2];
        recent_bytes[2] = b;

        if (p == POS_ADDR)
            addr_seen = b;
        else if (p == POS_ADDR_CHK)
        begin
            if (addr_seen != cfg_address || addr_seen != ~b)
                p = POS_IDLE;
        end

        if (p >= POS_DATA_FIRST && p <= end_pos)
        begin
            if (p % 2 == 1)
            begin
                payload_bank[fill_bank][(p - POS_DATA_FIRST) / 2] = b;
                last_data = b;
            end
            else if (b != ~last_data)
                p = POS_IDLE;
        end

        if (p == end_pos)
        begin
            parse_pos = POS_IDLE;
            for (int k = 0; k < len; k++)
            begin
                item.payload_byte  = payload_bank[fill_bank][k];
                item.payload_index = INDEX_W'(k);
                item.last          = (k + 1 == len);
                if (keep)
                    expected_payload.push_back(item);
            end
            fill_bank = ~fill_bank;
            return;
        end

        if (recent_bytes[0] + HEADER_STEP == recent_bytes[1] &&
            recent_bytes[1] + HEADER_STEP == recent_bytes[2])
            p = 0;

        if (p != POS_IDLE)
            p++;
        parse_pos = POS_W'(p);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                             input logic [BYTE_W-1:0] typed_byte = '0);
        while (tx_idle_on && $urandom_range(0, 99) < 28)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        deframe_byte(b, !typed);
        if (typed)
            expected_payload.push_back('{payload_byte: typed_byte, payload_index: '0,
                                         last: 1'b1});
        tx_count++;
        @(negedge clk);
    endtask

    task automatic send_packet(input int unsigned n_pairs, input flaw_t flaw);
        logic [BYTE_W-1:0] h;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] d;
        int unsigned       bad_pair;
        int unsigned       n_sent;
        h        = BYTE_W'($urandom_range(0, 251));
        addr     = cfg_address;
        bad_pair = $urandom_range(0, n_pairs - 1);
        n_sent   = (flaw == FLAW_TRUNCATED) ? $urandom_range(0, n_pairs - 1) : n_pairs;
        if (flaw == FLAW_ADDRESS)
            addr = addr ^ BYTE_W'($urandom_range(1, 255));
        send_byte(h);
        send_byte(h + 8'd2);
        send_byte(h + 8'd4);
        send_byte(addr);
        if (flaw == FLAW_ADDR_COMPLEMENT)
            send_byte(~addr ^ BYTE_W'($urandom_range(1, 255)));
        else
            send_byte(~addr);
        for (int i = 0; i < n_sent; i++)
        begin
            d = BYTE_W'($urandom);
            send_byte(d);
            if (flaw == FLAW_DATA_COMPLEMENT && i == bad_pair)
                send_byte(~d ^ BYTE_W'($urandom_range(1, 255)));
            else
                send_byte(~d);
        end
    endtask

    function automatic flaw_t pick_flaw();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return FLAW_NONE;
        if (r < 77)
            return FLAW_ADDRESS;
        if (r < 84)
            return FLAW_ADDR_COMPLEMENT;
        if (r < 92)
            return FLAW_DATA_COMPLEMENT;
        return FLAW_TRUNCATED;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        if (idx == REG_EXPECTED_ADDRESS)
            cfg_address = value;
        else if (idx == REG_PAYLOAD_LEN)
            cfg_length = value[LEN_CFG_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_payload.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** complement_checked_packet_deframer: FAILED **");
            $finish;
        end
    end

    // receiver
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready = 1'b0;
                rx_hold--;
            end
            else if (rx_idle_on)
                m_tready = ($urandom_range(0, 99) >= 28);
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_output
        payload_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_payload.size() == 0)
            begin
                $error("unexpected payload item: byte %0h index %0d last %0b",
                       m_tdata[BYTE_W-1:0], m_tdata[BYTE_W+INDEX_W-1:BYTE_W], m_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_payload.pop_front();
                if (m_tdata[BYTE_W-1:0] !== want.payload_byte)
                begin
                    $error("payload_byte: expected %0h, got %0h",
                           want.payload_byte, m_tdata[BYTE_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[BYTE_W+INDEX_W-1:BYTE_W] !== want.payload_index)
                begin
                    $error("payload_index: expected %0d, got %0d",
                           want.payload_index, m_tdata[BYTE_W+INDEX_W-1:BYTE_W]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] addr;
        int unsigned       budget;
        int unsigned       trunc_pairs;
        int                start_count;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        fail_count  = 0;
        cycle_count = 0;
        tx_count    = 0;
        rx_hold     = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;

        cfg_address = '0;
        cfg_length  = PAYLOAD_LEN_RST;
        foreach (recent_bytes[i])
            recent_bytes[i] = '0;
        parse_pos = POS_IDLE;
        addr_seen = '0;
        last_data = '0;
        fill_bank = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                      directed_rows[i].typed_byte);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // first phase runs both sides flat out
            tx_idle_on = (ph != 0);
            rx_idle_on = (ph != 0);
            if (ph == 1)
                addr = 8'hFF;
            else if (ph == 2)
                addr = 8'h00;
            else
                addr = BYTE_W'($urandom);
            write_reg(REG_EXPECTED_ADDRESS, addr);
            write_reg(REG_PAYLOAD_LEN, CFG_DATA_W'(phase_length[ph]));

            budget = (ph == PRESSURE_PHASE) ? 16 : 6;
            if (ph == PRESSURE_PHASE)
                rx_hold = HOLD_CYCLES;

            if (active_length() >= MAX_PAYLOAD_DEF)
                send_packet(active_length(), FLAW_NONE);
            else
            begin
                start_count = tx_count;
                while (tx_count - start_count < budget)
                begin
                    if ($urandom_range(0, 99) < 20)
                        repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
                    send_packet(active_length(),
                                (ph == PRESSURE_PHASE) ? FLAW_NONE : pick_flaw());
                end
            end

            // leave the parser mid-packet across the next length change
            if ($urandom_range(0, 1) == 1)
            begin
                trunc_pairs = (active_length() < 3) ? active_length() : 3;
                send_packet(trunc_pairs, FLAW_TRUNCATED);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("** complement_checked_packet_deframer: PASSED **");
        else
            $display("** complement_checked_packet_deframer: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ccpd_pkg.sv
sv/ccpd_mem.sv
sv/ccpd_parser.sv
sv/ccpd_readout.sv
sv/complement_checked_packet_deframer.sv
tb/complement_checked_packet_deframer_tb.sv
